// ----- rtl/core/sce_pkg.sv -----
`default_nettype none
package sce_pkg;

   // Field widths
   localparam int DATA_W     = 16;
   localparam int GOLD_W     = 6;
   localparam int NC_W       = 6;
   localparam int BATCH_W    = 16;
   localparam int KIND_W     = 2;
   localparam int RES_W      = 32;
   localparam int CLS_W      = 5;
   localparam int ROW_W      = 16;
   localparam int ACC_W      = 48;
   localparam int EXP_W      = 17;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam int MAX_CLASSES_DEF = 32;

   typedef logic [KIND_W-1:0]    kind_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   // Result kinds
   localparam kind_type KIND_GRAD = 2'd0;
   localparam kind_type KIND_LOSS = 2'd1;
   localparam kind_type KIND_ERR  = 2'd2;

   // Register indexes
   localparam csr_idx_type CSR_NUM_CLASSES = 2'd0;
   localparam csr_idx_type CSR_BATCH_SIZE  = 2'd1;
   localparam csr_idx_type CSR_UPSTREAM    = 2'd2;

   // Register reset values
   localparam logic [NC_W-1:0]    NUM_CLASSES_RST = 6'd10;
   localparam logic [BATCH_W-1:0] BATCH_SIZE_RST  = 16'd1;
   localparam logic [DATA_W-1:0]  UPSTREAM_RST    = 16'd16384;

   // Arithmetic constants
   localparam logic [16:0] LOG2E_Q16     = 17'd94548;
   localparam logic [29:0] LN2_Q30       = 30'd744261118;
   localparam logic [30:0] ONE_Q30       = 31'h4000_0000;
   localparam logic [15:0] ONE_Q14       = 16'd16384;
   localparam logic [3:0]  SERIES_TERMS  = 4'd12;
   localparam logic [3:0]  SQUARE_STEPS  = 4'd15;
   localparam logic [31:0] LOSS_SAT      = 32'h7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] LOGIT_MIN = 16'sh8000;

endpackage
`default_nettype wire

// ----- rtl/core/sce_if.sv -----
`default_nettype none
interface sce_req_if;
   import sce_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] logit;
   logic [GOLD_W-1:0]        gold_class;
   modport source (output valid, logit, gold_class, input ready);
   modport sink   (input valid, logit, gold_class, output ready);
endinterface

interface sce_rsp_if;
   import sce_pkg::*;
   logic                    valid;
   logic                    ready;
   kind_type                kind;
   logic signed [RES_W-1:0] result_value;
   logic [CLS_W-1:0]        class_index;
   logic [ROW_W-1:0]        row_index;
   logic                    last;
   modport source (output valid, kind, result_value, class_index, row_index, last,
                   input ready);
   modport sink   (input valid, kind, result_value, class_index, row_index, last,
                   output ready);
endinterface
`default_nettype wire

// ----- rtl/core/sce_ram.sv -----
`default_nettype none
module sce_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write one entry, register the read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

// ----- rtl/core/softmax_cross_entropy_loss_grad.sv -----
`default_nettype none
// Channel   Dir  Handshake      Payload
// req_chan  in   valid/ready    logit (s16 Q7.8), gold_class (u6)
// rsp_chan  out  valid/ready    kind, result_value, class_index, row_index, last
// csr_*     in   csr_wr_en      csr_index selects the register, csr_wr_data
//
// A logit that does not end a row is stored and its running maximum kept. A row end
// computes the exponent of each class (series skipped when it underflows), recomputes
// the maximum first when a lowered class count forces it, then the gradient of each
// class and the log of the sum, plus the mean loss at a batch end; the shared divider
// gives one quotient bit per cycle. Reset is synchronous, active high. A stalled
// result holds the sequencer; input is taken only when idle.
module softmax_cross_entropy_loss_grad #(
   parameter int unsigned MAX_CLASSES = sce_pkg::MAX_CLASSES_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   sce_req_if.sink                              req_chan,
   sce_rsp_if.source                            rsp_chan,
   input  wire logic                            csr_wr_en,
   input  wire logic [sce_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [sce_pkg::CSR_DATA_W-1:0]  csr_wr_data
);
   import sce_pkg::*;

   localparam int CW   = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
   localparam int ZW   = 17 + CW;
   localparam int DV_W = 49;
   localparam int DS_W = 31;

   // Sequencer states
   localparam logic [4:0] ST_IDLE  = 5'd0;
   localparam logic [4:0] ST_MX_RD = 5'd1;
   localparam logic [4:0] ST_MX_LD = 5'd2;
   localparam logic [4:0] ST_E_RD  = 5'd3;
   localparam logic [4:0] ST_E_LD  = 5'd4;
   localparam logic [4:0] ST_E_Y   = 5'd5;
   localparam logic [4:0] ST_E_U   = 5'd6;
   localparam logic [4:0] ST_E_TM  = 5'd7;
   localparam logic [4:0] ST_E_TD  = 5'd8;
   localparam logic [4:0] ST_E_TW  = 5'd9;
   localparam logic [4:0] ST_E_RND = 5'd10;
   localparam logic [4:0] ST_P_RD  = 5'd11;
   localparam logic [4:0] ST_P_LD  = 5'd12;
   localparam logic [4:0] ST_P_PW  = 5'd13;
   localparam logic [4:0] ST_P_MG  = 5'd14;
   localparam logic [4:0] ST_P_QW  = 5'd15;
   localparam logic [4:0] ST_P_EM  = 5'd16;
   localparam logic [4:0] ST_L_RD  = 5'd17;
   localparam logic [4:0] ST_L_LD  = 5'd18;
   localparam logic [4:0] ST_L_SQ  = 5'd19;
   localparam logic [4:0] ST_L_SQR = 5'd20;
   localparam logic [4:0] ST_L_LN  = 5'd21;
   localparam logic [4:0] ST_L_ACC = 5'd22;
   localparam logic [4:0] ST_M_DIV = 5'd23;
   localparam logic [4:0] ST_M_W   = 5'd24;
   localparam logic [4:0] ST_M_EM  = 5'd25;
   localparam logic [4:0] ST_K_EM  = 5'd26;

   // Configuration
   logic [NC_W-1:0]           num_classes_ff;
   logic [BATCH_W-1:0]        batch_ff;
   logic signed [DATA_W-1:0]  upstream_ff;

   // Control state
   logic [4:0]                state_ff, state_in;
   logic [CW-1:0]             cnt_ff, cnt_in;
   logic signed [DATA_W-1:0]  max_ff, max_in;
   logic [ROW_W-1:0]          rows_ff, rows_in;
   logic [ACC_W-1:0]          acc_ff, acc_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   // Working payload
   logic signed [DATA_W-1:0]  m_ff, m_in;
   logic [CW-1:0]             c_ff, c_in;
   logic [ZW-1:0]             z_ff, z_in;
   logic [CW-1:0]             gold_ff, gold_in;
   logic [4:0]                nexp_ff, nexp_in;
   logic [29:0]               u_ff, u_in;
   logic [30:0]               term_ff, term_in;
   logic [30:0]               sum_ff, sum_in;
   logic [3:0]                step_ff, step_in;
   logic [30:0]               f_ff, f_in;
   logic [15:0]               frac_ff, frac_in;
   logic [3:0]                pidx_ff, pidx_in;
   logic [15:0]               lossx_ff, lossx_in;
   logic                      sign_ff, sign_in;
   logic [RES_W-1:0]          res_ff, res_in;
   logic [63:0]               prod_ff;

   // Output register payload
   kind_type                  out_kind_ff, out_kind_in;
   logic [RES_W-1:0]          out_val_ff, out_val_in;
   logic [CLS_W-1:0]          out_cls_ff, out_cls_in;
   logic [ROW_W-1:0]          out_row_ff, out_row_in;
   logic                      out_last_ff, out_last_in;

   // Shared divider
   logic [30:0]               dv_rem_ff;
   logic [DV_W-1:0]           dv_quo_ff;
   logic [30:0]               dv_den_ff;
   logic [5:0]                dv_cnt_ff;
   logic                      dv_start, dv_long;
   logic [DV_W-1:0]           dv_num;
   logic [30:0]               dv_den;
   logic [31:0]               dv_trial;

   // Shared multiplier operands
   logic [31:0]               mul_a, mul_b;

   // Memories
   logic [CW-1:0]             row_rd_addr;
   logic [DATA_W-1:0]         row_rd_data;
   logic                      e_we;
   logic [EXP_W-1:0]          e_wdata, e_rd_data;

   // Helpers
   logic                      accept, emit_ok, last_c, batch_end;
   logic [NC_W-1:0]           n_eff;
   logic [BATCH_W-1:0]        b_eff;
   logic signed [DATA_W-1:0]  x_rd, max_x;
   logic [DATA_W-1:0]         diff_rd;
   logic [CW:0]               cnt_p1;
   logic [5:0]                shamt;
   logic [45:0]               rnd;
   logic [15:0]               g_val, g_mag, up_mag;
   logic [31:0]               sq_v;
   logic [49:0]               ln_sum;
   logic [3:0]                pidx_c;
   logic [30:0]               q_mag;

   assign accept        = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign emit_ok       = !rsp_valid_ff || rsp_chan.ready;

   // Clamp the class count and batch size
   always_comb begin
      if (num_classes_ff < 6'd2) begin
         n_eff = 6'd2;
      end else if (num_classes_ff > NC_W'(MAX_CLASSES)) begin
         n_eff = NC_W'(MAX_CLASSES);
      end else begin
         n_eff = num_classes_ff;
      end
   end
   assign b_eff = (batch_ff == '0) ? 16'd1 : batch_ff;

   assign cnt_p1    = (CW+1)'(cnt_ff) + 1'b1;
   assign last_c    = ((CW+1)'(c_ff) + 1'b1) == (CW+1)'(n_eff);
   assign batch_end = ({1'b0, rows_ff} + 17'd1) >= {1'b0, b_eff};
   assign max_x     = (req_chan.logit > max_ff) ? req_chan.logit : max_ff;
   assign x_rd      = row_rd_data;
   assign diff_rd   = DATA_W'(17'(m_ff) - 17'(x_rd));
   assign row_rd_addr = (state_ff == ST_L_RD) ? gold_ff : c_ff;

   // Locate the leading one of the exponent sum
   always_comb begin
      pidx_c = '0;
      for (int i = 16; i < ZW; i++) begin
         if (z_ff[i]) pidx_c = 4'(i - 16);
      end
   end

   assign shamt    = 6'(nexp_ff) + 6'd14;
   assign rnd      = (46'(sum_ff) + (46'd1 << (shamt - 6'd1))) >> shamt;
   assign g_val    = {1'b0, dv_quo_ff[14:0]} - ((CW'(c_ff) == gold_ff) ? ONE_Q14 : 16'd0);
   assign g_mag    = g_val[15] ? (16'd0 - g_val) : g_val;
   assign up_mag   = upstream_ff[15] ? (16'd0 - upstream_ff) : upstream_ff;
   assign sq_v     = prod_ff[61:30];
   assign ln_sum   = prod_ff[49:0] + (50'd1 << 29);
   assign q_mag    = dv_quo_ff[30:0];
   assign dv_trial = {dv_rem_ff, dv_quo_ff[DV_W-1]};

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      max_in       = max_ff;
      rows_in      = rows_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff;
      m_in         = m_ff;
      c_in         = c_ff;
      z_in         = z_ff;
      gold_in      = gold_ff;
      nexp_in      = nexp_ff;
      u_in         = u_ff;
      term_in      = term_ff;
      sum_in       = sum_ff;
      step_in      = step_ff;
      f_in         = f_ff;
      frac_in      = frac_ff;
      pidx_in      = pidx_ff;
      lossx_in     = lossx_ff;
      sign_in      = sign_ff;
      res_in       = res_ff;
      out_kind_in  = out_kind_ff;
      out_val_in   = out_val_ff;
      out_cls_in   = out_cls_ff;
      out_row_in   = out_row_ff;
      out_last_in  = out_last_ff;
      mul_a        = '0;
      mul_b        = '0;
      dv_start     = 1'b0;
      dv_long      = 1'b0;
      dv_num       = '0;
      dv_den       = '0;
      e_we         = 1'b0;
      e_wdata      = rnd[EXP_W-1:0];

      // Drop the result once taken
      if (rsp_valid_ff && rsp_chan.ready) rsp_valid_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (cnt_p1 < (CW+1)'(n_eff)) begin
                  cnt_in = CW'(cnt_p1);
                  max_in = max_x;
               end else begin
                  cnt_in  = '0;
                  max_in  = LOGIT_MIN;
                  gold_in = CW'(req_chan.gold_class);
                  c_in    = '0;
                  z_in    = '0;
                  if (req_chan.gold_class >= n_eff) begin
                     state_in = ST_K_EM;
                  end else if (cnt_p1 == (CW+1)'(n_eff)) begin
                     m_in     = max_x;
                     state_in = ST_E_RD;
                  end else begin
                     m_in     = LOGIT_MIN;
                     state_in = ST_MX_RD;
                  end
               end
            end
         end
         // Recompute the maximum over the first n stored logits
         ST_MX_RD: state_in = ST_MX_LD;
         ST_MX_LD: begin
            if (x_rd > m_ff) m_in = x_rd;
            if (last_c) begin
               c_in     = '0;
               state_in = ST_E_RD;
            end else begin
               c_in     = c_ff + 1'b1;
               state_in = ST_MX_RD;
            end
         end
         // Exponent of each logit against the row maximum
         ST_E_RD: state_in = ST_E_LD;
         ST_E_LD: begin
            mul_a    = 32'(diff_rd);
            mul_b    = 32'(LOG2E_Q16);
            state_in = ST_E_Y;
         end
         ST_E_Y: begin
            if (prod_ff[32:24] > 9'd30) begin
               sum_in   = '0;
               nexp_in  = '0;
               state_in = ST_E_RND;
            end else begin
               nexp_in  = prod_ff[28:24];
               mul_a    = 32'(prod_ff[23:0]);
               mul_b    = 32'(LN2_Q30);
               state_in = ST_E_U;
            end
         end
         ST_E_U: begin
            u_in     = prod_ff[53:24];
            term_in  = ONE_Q30;
            sum_in   = ONE_Q30;
            step_in  = 4'd1;
            state_in = ST_E_TM;
         end
         ST_E_TM: begin
            mul_a    = 32'(term_ff);
            mul_b    = 32'(u_ff);
            state_in = ST_E_TD;
         end
         ST_E_TD: begin
            dv_start = 1'b1;
            dv_num   = DV_W'(prod_ff[60:30]);
            dv_den   = 31'(step_ff);
            state_in = ST_E_TW;
         end
         ST_E_TW: begin
            if (dv_cnt_ff == '0) begin
               term_in = q_mag;
               sum_in  = step_ff[0] ? (sum_ff - q_mag) : (sum_ff + q_mag);
               if (step_ff == SERIES_TERMS) begin
                  state_in = ST_E_RND;
               end else begin
                  step_in  = step_ff + 1'b1;
                  state_in = ST_E_TM;
               end
            end
         end
         ST_E_RND: begin
            e_we = 1'b1;
            z_in = z_ff + ZW'(rnd[EXP_W-1:0]);
            if (last_c) begin
               c_in     = '0;
               state_in = ST_P_RD;
            end else begin
               c_in     = c_ff + 1'b1;
               state_in = ST_E_RD;
            end
         end
         // Probability and gradient per class
         ST_P_RD: state_in = ST_P_LD;
         ST_P_LD: begin
            dv_start = 1'b1;
            dv_num   = DV_W'({e_rd_data, 14'd0}) + DV_W'(z_ff >> 1);
            dv_den   = 31'(z_ff);
            state_in = ST_P_PW;
         end
         ST_P_PW: begin
            if (dv_cnt_ff == '0) begin
               sign_in  = g_val[15] ^ upstream_ff[15];
               mul_a    = 32'(g_mag);
               mul_b    = 32'(up_mag);
               state_in = ST_P_MG;
            end
         end
         ST_P_MG: begin
            dv_start = 1'b1;
            dv_num   = DV_W'(prod_ff[29:0]) + DV_W'({b_eff, 13'd0});
            dv_den   = 31'({b_eff, 14'd0});
            state_in = ST_P_QW;
         end
         ST_P_QW: begin
            if (dv_cnt_ff == '0) begin
               if (sign_ff) begin
                  res_in = (q_mag > 31'd32768) ? 32'hFFFF_8000 : (32'd0 - 32'(q_mag));
               end else begin
                  res_in = (q_mag > 31'd32767) ? 32'h0000_7FFF : 32'(q_mag);
               end
               state_in = ST_P_EM;
            end
         end
         ST_P_EM: begin
            if (emit_ok) begin
               rsp_valid_in = 1'b1;
               out_kind_in  = KIND_GRAD;
               out_val_in   = res_ff;
               out_cls_in   = CLS_W'(c_ff);
               out_row_in   = rows_ff;
               out_last_in  = last_c && !batch_end;
               if (last_c) begin
                  state_in = ST_L_RD;
               end else begin
                  c_in     = c_ff + 1'b1;
                  state_in = ST_P_RD;
               end
            end
         end
         // Row loss: max minus gold logit, plus ln of the sum
         ST_L_RD: state_in = ST_L_LD;
         ST_L_LD: begin
            lossx_in = diff_rd;
            pidx_in  = pidx_c;
            f_in     = 31'(z_ff) << (4'd14 - pidx_c);
            frac_in  = '0;
            step_in  = '0;
            state_in = ST_L_SQ;
         end
         ST_L_SQ: begin
            mul_a    = 32'(f_ff);
            mul_b    = 32'(f_ff);
            state_in = ST_L_SQR;
         end
         ST_L_SQR: begin
            if (sq_v[31]) begin
               f_in    = sq_v[31:1];
               frac_in = {frac_ff[14:0], 1'b1};
            end else begin
               f_in    = sq_v[30:0];
               frac_in = {frac_ff[14:0], 1'b0};
            end
            if (step_ff == SQUARE_STEPS) begin
               state_in = ST_L_LN;
            end else begin
               step_in  = step_ff + 1'b1;
               state_in = ST_L_SQ;
            end
         end
         ST_L_LN: begin
            mul_a    = 32'({pidx_ff, frac_ff});
            mul_b    = 32'(LN2_Q30);
            state_in = ST_L_ACC;
         end
         ST_L_ACC: begin
            acc_in = acc_ff + ACC_W'({lossx_ff, 8'd0}) + ACC_W'(ln_sum[49:30]);
            if (batch_end) begin
               state_in = ST_M_DIV;
            end else begin
               rows_in  = rows_ff + 1'b1;
               state_in = ST_IDLE;
            end
         end
         // Mean loss at batch end
         ST_M_DIV: begin
            dv_start = 1'b1;
            dv_long  = 1'b1;
            dv_num   = DV_W'(acc_ff) + DV_W'(b_eff >> 1);
            dv_den   = 31'(b_eff);
            state_in = ST_M_W;
         end
         ST_M_W: begin
            if (dv_cnt_ff == '0) begin
               res_in   = (dv_quo_ff > DV_W'(LOSS_SAT)) ? LOSS_SAT : dv_quo_ff[31:0];
               state_in = ST_M_EM;
            end
         end
         ST_M_EM: begin
            if (emit_ok) begin
               rsp_valid_in = 1'b1;
               out_kind_in  = KIND_LOSS;
               out_val_in   = res_ff;
               out_cls_in   = '0;
               out_row_in   = rows_ff;
               out_last_in  = 1'b1;
               acc_in       = '0;
               rows_in      = '0;
               state_in     = ST_IDLE;
            end
         end
         // Gold class out of range: drop the row
         ST_K_EM: begin
            if (emit_ok) begin
               rsp_valid_in = 1'b1;
               out_kind_in  = KIND_ERR;
               out_val_in   = '0;
               out_cls_in   = '0;
               out_row_in   = rows_ff;
               out_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         cnt_ff         <= '0;
         max_ff         <= LOGIT_MIN;
         rows_ff        <= '0;
         acc_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
         dv_cnt_ff      <= '0;
         num_classes_ff <= NUM_CLASSES_RST;
         batch_ff       <= BATCH_SIZE_RST;
         upstream_ff    <= UPSTREAM_RST;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         max_ff       <= max_in;
         rows_ff      <= rows_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
         if (dv_start) begin
            dv_cnt_ff <= dv_long ? 6'(DV_W) : 6'(DS_W);
         end else if (dv_cnt_ff != '0) begin
            dv_cnt_ff <= dv_cnt_ff - 1'b1;
         end
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_NUM_CLASSES: num_classes_ff <= csr_wr_data[NC_W-1:0];
               CSR_BATCH_SIZE:  batch_ff       <= csr_wr_data;
               CSR_UPSTREAM:    upstream_ff    <= csr_wr_data;
               default: ;
            endcase
         end
      end
   end

   // Payload registers, multiplier and divider datapath
   always_ff @(posedge clock) begin
      m_ff        <= m_in;
      c_ff        <= c_in;
      z_ff        <= z_in;
      gold_ff     <= gold_in;
      nexp_ff     <= nexp_in;
      u_ff        <= u_in;
      term_ff     <= term_in;
      sum_ff      <= sum_in;
      step_ff     <= step_in;
      f_ff        <= f_in;
      frac_ff     <= frac_in;
      pidx_ff     <= pidx_in;
      lossx_ff    <= lossx_in;
      sign_ff     <= sign_in;
      res_ff      <= res_in;
      out_kind_ff <= out_kind_in;
      out_val_ff  <= out_val_in;
      out_cls_ff  <= out_cls_in;
      out_row_ff  <= out_row_in;
      out_last_ff <= out_last_in;
      prod_ff     <= 64'(mul_a) * 64'(mul_b);
      // Restoring division, one quotient bit per cycle
      if (dv_start) begin
         dv_rem_ff <= '0;
         dv_den_ff <= dv_den;
         dv_quo_ff <= dv_long ? dv_num : {dv_num[DS_W-1:0], (DV_W-DS_W)'(0)};
      end else if (dv_cnt_ff != '0) begin
         if (dv_trial >= {1'b0, dv_den_ff}) begin
            dv_rem_ff <= 31'(dv_trial - {1'b0, dv_den_ff});
            dv_quo_ff <= {dv_quo_ff[DV_W-2:0], 1'b1};
         end else begin
            dv_rem_ff <= dv_trial[30:0];
            dv_quo_ff <= {dv_quo_ff[DV_W-2:0], 1'b0};
         end
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.kind         = out_kind_ff;
   assign rsp_chan.result_value = out_val_ff;
   assign rsp_chan.class_index  = out_cls_ff;
   assign rsp_chan.row_index    = out_row_ff;
   assign rsp_chan.last         = out_last_ff;

   // Logits of the current row
   sce_ram #(.WIDTH(DATA_W), .DEPTH(MAX_CLASSES)) u_row_ram (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (cnt_ff),
      .wr_data (req_chan.logit),
      .rd_addr (row_rd_addr),
      .rd_data (row_rd_data)
   );

   // Exponents of the current row
   sce_ram #(.WIDTH(EXP_W), .DEPTH(MAX_CLASSES)) u_exp_ram (
      .clock   (clock),
      .wr_en   (e_we),
      .wr_addr (c_ff),
      .wr_data (e_wdata),
      .rd_addr (c_ff),
      .rd_data (e_rd_data)
   );

endmodule
`default_nettype wire

// ----- bench/softmax_cross_entropy_loss_grad_tb.sv -----
`timescale 1ns / 100ps
module softmax_cross_entropy_loss_grad_tb;
   import sce_pkg::*;

   localparam int N_ITEMS   = 420;
   localparam int STALL_MAX = 150000;
   localparam int SETTLE    = 80;

   typedef struct {
      kind_type          kind;
      logic [RES_W-1:0]  val;
      logic [CLS_W-1:0]  cls;
      logic [ROW_W-1:0]  row;
      logic              last;
   } rsp_t;

   typedef enum {STEP_CFG, STEP_LOGIT} step_kind_e;

   typedef struct {
      step_kind_e                  op;
      csr_idx_type                 idx;
      logic [CSR_DATA_W-1:0]       data;
      logic signed [DATA_W-1:0]    logit;
      logic [GOLD_W-1:0]           gold;
      int                          n_typed;
      rsp_t                        typed[3];
   } step_t;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;

   sce_req_if req_bus ();
   sce_rsp_if rsp_bus ();

   softmax_cross_entropy_loss_grad i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // Softmax state mirror
   logic signed [DATA_W-1:0] row_logits[32];
   int unsigned              class_pos;
   int unsigned              row_pos;
   logic signed [DATA_W-1:0] row_peak;
   logic [ACC_W-1:0]         loss_sum;
   logic [NC_W-1:0]          classes_reg;
   logic [BATCH_W-1:0]       batch_reg;
   logic signed [15:0]       seed_grad_reg;

   rsp_t  grad_loss_q[$];
   step_t dir_steps[$];
   int    err_cnt;
   int    logits_sent;
   bit    calm;
   bit    req_fire;
   bit    rsp_fire;
   int    stall_cnt;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // e^d in Q.16 for d <= 0 in Q7.8
   function automatic longint unsigned exp_q16(longint signed d);
      longint unsigned t, y, n, u, term, sum;
      int unsigned s;
      t = longint'(-d);
      y = t * LOG2E_Q16;
      n = y >> 24;
      if (n > 30) return 0;
      u = ((y & 64'hFF_FFFF) * LN2_Q30) >> 24;
      term = 64'd1 << 30;
      sum = 64'd1 << 30;
      for (int k = 1; k <= 12; k++) begin
         term = ((term * u) >> 30) / k;
         if (k % 2 == 1) sum -= term;
         else sum += term;
      end
      s = 14 + n;
      return (sum + (64'd1 << (s - 1))) >> s;
   endfunction

   // ln(z / 2^16) in Q.16 by repeated squaring
   function automatic longint unsigned ln_q16(longint unsigned z);
      int unsigned p;
      longint unsigned f, frac, lg;
      p = 16;
      frac = 0;
      while (p < 40 && (z >> (p + 1)) != 0) p++;
      f = z << (30 - p);
      for (int i = 0; i < 16; i++) begin
         f = (f * f) >> 30;
         frac = frac << 1;
         if (f >= (64'd1 << 31)) begin
            f = f >> 1;
            frac = frac | 1;
         end
      end
      lg = (longint'(p - 16) << 16) | frac;
      return (lg * LN2_Q30 + (64'd1 << 29)) >> 30;
   endfunction

   // Advance the softmax mirror by one logit; queue the results if asked
   function automatic void softmax_step(logic signed [DATA_W-1:0] x, logic [GOLD_W-1:0] gold,
                                        bit keep);
      int unsigned n, idx;
      longint signed m, up, p, g, num, q;
      longint unsigned e[32], z, b, den, mag, mean;
      rsp_t r;
      rsp_t outs[$];
      n = classes_reg;
      if (n < 2) n = 2;
      if (n > 32) n = 32;
      idx = (class_pos >= 32) ? 31 : class_pos;
      row_logits[idx] = x;
      if (x > row_peak) row_peak = x;
      class_pos = (class_pos + 1) & 63;
      if (class_pos < n) return;
      if (class_pos == n) begin
         m = row_peak;
      end else begin
         m = row_logits[0];
         for (int c = 1; c < n; c++) if (row_logits[c] > m) m = row_logits[c];
      end
      class_pos = 0;
      row_peak = LOGIT_MIN;
      if (gold >= n) begin
         r = '{KIND_ERR, '0, '0, row_pos[15:0], 1'b1};
         if (keep) grad_loss_q.push_back(r);
         return;
      end
      b = (batch_reg != 0) ? batch_reg : 1;
      up = seed_grad_reg;
      den = b * 16384;
      z = 0;
      for (int c = 0; c < n; c++) begin
         e[c] = exp_q16(longint'(row_logits[c]) - m);
         z += e[c];
      end
      for (int c = 0; c < n; c++) begin
         p = longint'((e[c] * 16384 + z / 2) / z);
         g = p - ((c == gold) ? 16384 : 0);
         num = g * up;
         mag = (num < 0) ? -num : num;
         q = longint'((mag + den / 2) / den);
         if (num < 0) q = -q;
         if (q > 32767) q = 32767;
         if (q < -32768) q = -32768;
         r = '{KIND_GRAD, q[31:0], c[4:0], row_pos[15:0], 1'b0};
         outs.push_back(r);
      end
      loss_sum = ACC_W'(loss_sum + ((m - longint'(row_logits[gold])) << 8) + ln_q16(z));
      if (longint'(row_pos) + 1 >= b) begin
         mean = (64'(loss_sum) + b / 2) / b;
         if (mean > 64'h7FFF_FFFF) mean = 64'h7FFF_FFFF;
         r = '{KIND_LOSS, mean[31:0], '0, row_pos[15:0], 1'b0};
         outs.push_back(r);
         loss_sum = '0;
         row_pos = 0;
      end else begin
         row_pos = (row_pos + 1) & 16'hFFFF;
      end
      outs[outs.size()-1].last = 1'b1;
      if (keep) foreach (outs[i]) grad_loss_q.push_back(outs[i]);
   endfunction

   // Hold off input until every result is back and the block settles
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (grad_loss_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(csr_idx_type idx, logic [CSR_DATA_W-1:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_NUM_CLASSES: classes_reg   = data[NC_W-1:0];
         CSR_BATCH_SIZE:  batch_reg     = data;
         CSR_UPSTREAM:    seed_grad_reg = data;
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Send one logit; typed results replace the prediction when given
   task automatic send_logit(logic signed [DATA_W-1:0] x, logic [GOLD_W-1:0] gold,
                             int n_typed, rsp_t typed[3]);
      while (!calm && $urandom_range(99) < 23) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.logit      <= x;
      req_bus.gold_class <= gold;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      softmax_step(x, gold, n_typed == 0);
      for (int i = 0; i < n_typed; i++) grad_loss_q.push_back(typed[i]);
      logits_sent++;
   endtask

   task automatic add_cfg(csr_idx_type idx, logic [CSR_DATA_W-1:0] data);
      step_t s;
      s = '{op: STEP_CFG, default: '0};
      s.idx = idx;
      s.data = data;
      dir_steps.push_back(s);
   endtask

   task automatic add_logit(logic signed [DATA_W-1:0] x, logic [GOLD_W-1:0] gold);
      step_t s;
      s = '{op: STEP_LOGIT, default: '0};
      s.logit = x;
      s.gold = gold;
      dir_steps.push_back(s);
   endtask

   task automatic add_typed(kind_type kind, logic [RES_W-1:0] val, logic [CLS_W-1:0] cls,
                            logic [ROW_W-1:0] row, logic last);
      int k;
      k = dir_steps.size() - 1;
      dir_steps[k].typed[dir_steps[k].n_typed] = '{kind, val, cls, row, last};
      dir_steps[k].n_typed++;
   endtask

   // Result side: random back-pressure and in-order compare
   always @(posedge clock) begin
      rsp_t want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= calm || ($urandom_range(99) >= 23);
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (grad_loss_q.size() == 0) begin
               $display("%0t: unexpected result kind=%0d value=%0d", $time,
                        rsp_bus.kind, rsp_bus.result_value);
               err_cnt++;
            end else begin
               want = grad_loss_q.pop_front();
               if (rsp_bus.kind !== want.kind) begin
                  $display("%0t: kind expected %0d actual %0d", $time, want.kind, rsp_bus.kind);
                  err_cnt++;
               end
               if (rsp_bus.result_value !== want.val) begin
                  $display("%0t: result_value expected %0d actual %0d", $time,
                           $signed(want.val), rsp_bus.result_value);
                  err_cnt++;
               end
               if (rsp_bus.class_index !== want.cls) begin
                  $display("%0t: class_index expected %0d actual %0d", $time, want.cls,
                           rsp_bus.class_index);
                  err_cnt++;
               end
               if (rsp_bus.row_index !== want.row) begin
                  $display("%0t: row_index expected %0d actual %0d", $time, want.row,
                           rsp_bus.row_index);
                  err_cnt++;
               end
               if (rsp_bus.last !== want.last) begin
                  $display("%0t: last expected %0d actual %0d", $time, want.last, rsp_bus.last);
                  err_cnt++;
               end
            end
         end
      end
   end

   // Watchdog on cycles with no transaction on either channel
   always @(posedge clock) begin
      req_fire = req_bus.valid && req_bus.ready;
      rsp_fire = rsp_bus.valid && rsp_bus.ready;
      if (reset || req_fire || rsp_fire) begin
         stall_cnt <= 0;
      end else if (stall_cnt >= STALL_MAX) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         stall_cnt <= stall_cnt + 1;
      end
   end

   initial begin
      rsp_t none[3];
      int n_eff, n_rows, k, big_rows;
      logic signed [DATA_W-1:0] base;
      logic [GOLD_W-1:0] gold;
      none = '{default: '{default: '0}};
      err_cnt = 0;
      logits_sent = 0;
      calm = 1'b0;
      stall_cnt = 0;
      big_rows = 0;
      reset = 1'b1;
      csr_wr_en <= 1'b0;
      csr_index <= CSR_NUM_CLASSES;
      csr_wr_data <= '0;
      req_bus.valid <= 1'b0;
      req_bus.logit <= '0;
      req_bus.gold_class <= '0;
      for (int i = 0; i < 32; i++) row_logits[i] = '0;
      class_pos = 0;
      row_pos = 0;
      row_peak = LOGIT_MIN;
      loss_sum = '0;
      classes_reg = NUM_CLASSES_RST;
      batch_reg = BATCH_SIZE_RST;
      seed_grad_reg = UPSTREAM_RST;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed steps: two equal logits, extreme logits, gold out of range,
      // zero and full batch sizes, extreme seeds, class count lowered mid row
      add_cfg(CSR_NUM_CLASSES, 16'd2);
      add_logit(16'sd0, 6'd1);
      add_logit(16'sd0, 6'd0);
      add_typed(KIND_GRAD, -32'sd8192, 5'd0, 16'd0, 1'b0);
      add_typed(KIND_GRAD, 32'sd8192, 5'd1, 16'd0, 1'b0);
      add_typed(KIND_LOSS, 32'sd45426, 5'd0, 16'd0, 1'b1);
      add_logit(16'sh7FFF, 6'd0);
      add_logit(16'sh8000, 6'd1);
      add_logit(16'sh8000, 6'd0);
      add_logit(16'sh8000, 6'd63);
      add_typed(KIND_ERR, 32'sd0, 5'd0, 16'd0, 1'b1);
      add_cfg(CSR_BATCH_SIZE, 16'd0);
      add_cfg(CSR_UPSTREAM, 16'h8000);
      add_logit(16'sd100, 6'd0);
      add_logit(-16'sd100, 6'd1);
      add_cfg(CSR_UPSTREAM, 16'h7FFF);
      add_cfg(CSR_BATCH_SIZE, 16'hFFFF);
      add_logit(16'sd5, 6'd0);
      add_logit(16'sd7, 6'd0);
      add_cfg(CSR_BATCH_SIZE, 16'd2);
      add_logit(16'sd1, 6'd0);
      add_logit(16'sd2, 6'd1);
      add_cfg(CSR_NUM_CLASSES, 16'd5);
      add_logit(16'sd0, 6'd0);
      add_logit(16'sd1, 6'd0);
      add_logit(16'sd2, 6'd0);
      add_logit(16'sd3, 6'd0);
      add_cfg(CSR_NUM_CLASSES, 16'd3);
      add_logit(16'sd9, 6'd2);
      add_cfg(CSR_NUM_CLASSES, 16'd0);
      add_logit(-16'sd5, 6'd0);
      add_logit(16'sd5, 6'd1);

      foreach (dir_steps[i]) begin
         if (dir_steps[i].op == STEP_CFG) begin
            drain_results();
            write_reg(dir_steps[i].idx, dir_steps[i].data);
         end else begin
            send_logit(dir_steps[i].logit, dir_steps[i].gold, dir_steps[i].n_typed,
                       dir_steps[i].typed);
         end
      end

      // Random phases: new settings, then a few rows
      while (logits_sent < N_ITEMS) begin
         drain_results();
         k = $urandom_range(99);
         if (k < 8 && big_rows < 5) begin
            big_rows++;
            write_reg(CSR_NUM_CLASSES, ($urandom_range(1) != 0) ? 16'd32 : 16'($urandom_range(33, 63)));
         end else if (k < 12) begin
            write_reg(CSR_NUM_CLASSES, 16'($urandom_range(1)));
         end else if (k < 75) begin
            write_reg(CSR_NUM_CLASSES, 16'($urandom_range(2, 6)));
         end else if (k < 85) begin
            write_reg(CSR_NUM_CLASSES, 16'($urandom_range(7, 12)));
         end
         k = $urandom_range(99);
         if (k < 10) write_reg(CSR_BATCH_SIZE, 16'hFFFF);
         else if (k < 15) write_reg(CSR_BATCH_SIZE, 16'd0);
         else if (k < 60) write_reg(CSR_BATCH_SIZE, 16'($urandom_range(1, 4)));
         k = $urandom_range(99);
         if (k < 10) write_reg(CSR_UPSTREAM, ($urandom_range(1) != 0) ? 16'h8000 : 16'h7FFF);
         else if (k < 60) write_reg(CSR_UPSTREAM, 16'($urandom));
         n_eff = classes_reg;
         if (n_eff < 2) n_eff = 2;
         if (n_eff > 32) n_eff = 32;
         n_rows = (n_eff > 12) ? 1 : $urandom_range(1, 4);
         for (int r = 0; r < n_rows; r++) begin
            calm = (logits_sent >= 150 && logits_sent < 230);
            base = 16'($urandom);
            gold = ($urandom_range(99) < 88) ? 6'($urandom_range(n_eff - 1))
                                             : 6'($urandom_range(63));
            // Cut a row short and shrink the class count now and then
            if (n_eff > 2 && n_eff <= 12 && $urandom_range(99) < 6) begin
               k = $urandom_range(1, n_eff - 1);
               for (int c = 0; c < k; c++) send_logit(16'($urandom), 6'($urandom), 0, none);
               drain_results();
               write_reg(CSR_NUM_CLASSES, 16'($urandom_range(2, k)));
               send_logit(16'($urandom), gold, 0, none);
               break;
            end
            for (int c = 0; c < n_eff; c++) begin
               if ($urandom_range(99) < 30)
                  send_logit(16'($urandom), (c == n_eff - 1) ? gold : 6'($urandom), 0, none);
               else
                  send_logit(base + 16'($urandom_range(2047)) - 16'sd1024,
                             (c == n_eff - 1) ? gold : 6'($urandom), 0, none);
            end
         end
         calm = 1'b0;
      end

      // Wind down
      req_bus.valid <= 1'b0;
      while (grad_loss_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (err_cnt == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/core/sce_pkg.sv
rtl/core/sce_if.sv
rtl/core/sce_ram.sv
rtl/core/softmax_cross_entropy_loss_grad.sv
bench/softmax_cross_entropy_loss_grad_tb.sv
